@@ rtl/t2c_pkg.sv @@
package t2c_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_COLS    = 256;

    localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
    localparam int COL_AW   = $clog2(MAX_COLS);
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);

    localparam int ROW_W     = 16;
    localparam int COL_W     = 8;
    localparam int VALUE_W   = 64;
    localparam int IDX_W     = 11;
    localparam int POS_W     = 10;
    localparam int NCOLS_W   = 9;
    localparam int CFG_W     = 9;
    localparam int REG_IDX_W = 1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_NUM_COLS     = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_CARRY_VALUES = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_RMW,
        ST_PFX_RD,
        ST_PFX_WR,
        ST_SCT_RD,
        ST_SCT_CNT,
        ST_SCT_WR,
        ST_FINISH,
        ST_READ_MEM,
        ST_READ_OUT
    } state_t;

    typedef struct packed {
        logic [COL_AW-1:0] rd_addr;
        logic              wr_en;
        logic [COL_AW-1:0] wr_addr;
        logic [CNT_W-1:0]  wr_data;
        logic              clear_all;
    } cnt_ctl_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic [VALUE_W-1:0] value;
    } staged_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [VALUE_W-1:0] value;
    } placed_t;

endpackage

@@ rtl/t2c_in_if.sv @@
interface t2c_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [t2c_pkg::ROW_W-1:0]    row;
    logic [t2c_pkg::COL_W-1:0]    column;
    logic [t2c_pkg::VALUE_W-1:0]  value;
    logic                         last;
    logic [t2c_pkg::IDX_W-1:0]    read_index;

    modport source (output valid, kind, row, column, value, last, read_index, input ready);
    modport sink (input valid, kind, row, column, value, last, read_index, output ready);
endinterface

@@ rtl/t2c_out_if.sv @@
interface t2c_out_if;
    logic                         valid;
    logic                         ready;
    logic [t2c_pkg::ROW_W-1:0]    entry_row;
    logic [t2c_pkg::VALUE_W-1:0]  entry_value;
    logic [t2c_pkg::CNT_W-1:0]    column_start;
    logic [t2c_pkg::POS_W-1:0]    new_position;
    logic [t2c_pkg::CNT_W-1:0]    total_entries;
    logic                         overflow;

    modport source (output valid, entry_row, entry_value, column_start, new_position,
                    total_entries, overflow, input ready);
    modport sink (input valid, entry_row, entry_value, column_start, new_position,
                  total_entries, overflow, output ready);
endinterface

@@ rtl/triplet_to_csc_convert.sv @@
// Load word: count read, then increment and write back.
// Read word: address, memory read, then result into the output register.
// Last load: prefix pass over all 256 columns, scatter pass over the N staged triplets,
// finish; the count memory's single read and write port sets prefix and scatter pace.
// Reset clears control state and all column counts at once (valid bits); no clearing pass.
module triplet_to_csc_convert (
    input  logic                          clk,
    input  logic                          rst_n,
    t2c_in_if.sink                        items,
    t2c_out_if.source                     results,
    input  logic                          cfg_we,
    input  logic [t2c_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [t2c_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int CNT_W    = t2c_pkg::CNT_W;
    localparam int ENTRY_AW = t2c_pkg::ENTRY_AW;
    localparam int COL_AW   = t2c_pkg::COL_AW;
    localparam int IDX_W    = t2c_pkg::IDX_W;
    localparam int NCOLS_W  = t2c_pkg::NCOLS_W;

    t2c_pkg::state_t state_reg, state_next;

    logic [NCOLS_W-1:0] num_cols_reg;
    logic               carry_reg;

    logic [CNT_W-1:0]    load_count_reg, load_count_next;
    logic                pend_ovf_reg, pend_ovf_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic                ovf_reg, ovf_next;
    logic [COL_AW-1:0]   col_reg, col_next;
    logic                last_reg, last_next;
    logic [COL_AW-1:0]   c_reg, c_next;
    logic [CNT_W-1:0]    sum_reg, sum_next;
    logic [ENTRY_AW-1:0] k_reg, k_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;

    logic [t2c_pkg::ROW_W-1:0]   out_row_reg;
    logic [t2c_pkg::VALUE_W-1:0] out_value_reg;
    logic [CNT_W-1:0]            out_start_reg;
    logic [t2c_pkg::POS_W-1:0]   out_pos_reg;
    logic [CNT_W-1:0]            out_total_reg;
    logic                        out_ovf_reg;

    t2c_pkg::staged_t   staged_mem [t2c_pkg::MAX_ENTRIES];
    t2c_pkg::placed_t   placed_mem [t2c_pkg::MAX_ENTRIES];
    logic [ENTRY_AW-1:0] o2n_mem    [t2c_pkg::MAX_ENTRIES];
    logic [CNT_W-1:0]    starts_mem [t2c_pkg::MAX_COLS];

    t2c_pkg::staged_t    st_rd_reg;
    t2c_pkg::placed_t    pl_rd_reg;
    logic [ENTRY_AW-1:0] o2n_rd_reg;
    logic [CNT_W-1:0]    starts_rd_reg;

    logic                st_we;
    t2c_pkg::staged_t    st_wdata;
    logic                pl_we;
    logic [ENTRY_AW-1:0] pl_waddr;
    t2c_pkg::placed_t    pl_wdata;
    logic                o2n_we;
    logic                starts_we;

    t2c_pkg::cnt_ctl_t cnt_ctl;
    logic [CNT_W-1:0]  rd_count;

    // The one shared adder: column count increments and the running prefix sum.
    logic [CNT_W-1:0] add_a, add_b, add_sum;

    logic               in_fire;
    logic [NCOLS_W-1:0] cols_in_use;
    logic               col_ok;
    logic               room;
    logic               last_col;
    logic [CNT_W-1:0]   k_inc;
    logic               idx_lt_cols;
    logic               idx_lt_total;

    assign add_sum = add_a + add_b;

    assign in_fire     = items.valid && items.ready;
    assign cols_in_use = (num_cols_reg > NCOLS_W'(t2c_pkg::MAX_COLS))
                         ? NCOLS_W'(t2c_pkg::MAX_COLS) : num_cols_reg;
    assign col_ok      = NCOLS_W'(items.column) < cols_in_use;
    assign room        = load_count_reg != CNT_W'(t2c_pkg::MAX_ENTRIES);
    assign last_col    = c_reg == COL_AW'(t2c_pkg::MAX_COLS - 1);
    assign k_inc       = CNT_W'(k_reg) + CNT_W'(1);
    assign idx_lt_cols  = idx_reg < IDX_W'(cols_in_use);
    assign idx_lt_total = idx_reg < total_reg;

    assign items.ready = state_reg == t2c_pkg::ST_IDLE;

    t2c_counts u_counts (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cnt_ctl),
        .rd_count (rd_count)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= NCOLS_W'(t2c_pkg::MAX_COLS);
            carry_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                t2c_pkg::REG_NUM_COLS:     num_cols_reg <= cfg_wdata[NCOLS_W-1:0];
                t2c_pkg::REG_CARRY_VALUES: carry_reg    <= cfg_wdata[0];
                default:                   ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            t2c_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (items.kind == t2c_pkg::KIND_READ)
                    begin
                        state_next = t2c_pkg::ST_READ_MEM;
                    end
                    else if (col_ok && room)
                    begin
                        state_next = t2c_pkg::ST_LOAD_RMW;
                    end
                    else if (items.last)
                    begin
                        state_next = t2c_pkg::ST_PFX_RD;
                    end
                end
            end
            t2c_pkg::ST_LOAD_RMW:
            begin
                state_next = last_reg ? t2c_pkg::ST_PFX_RD : t2c_pkg::ST_IDLE;
            end
            t2c_pkg::ST_PFX_RD:
            begin
                state_next = t2c_pkg::ST_PFX_WR;
            end
            t2c_pkg::ST_PFX_WR:
            begin
                if (last_col)
                begin
                    state_next = (load_count_reg == '0) ? t2c_pkg::ST_FINISH
                                                        : t2c_pkg::ST_SCT_RD;
                end
                else
                begin
                    state_next = t2c_pkg::ST_PFX_RD;
                end
            end
            t2c_pkg::ST_SCT_RD:
            begin
                state_next = t2c_pkg::ST_SCT_CNT;
            end
            t2c_pkg::ST_SCT_CNT:
            begin
                state_next = t2c_pkg::ST_SCT_WR;
            end
            t2c_pkg::ST_SCT_WR:
            begin
                state_next = (k_inc == load_count_reg) ? t2c_pkg::ST_FINISH
                                                       : t2c_pkg::ST_SCT_RD;
            end
            t2c_pkg::ST_FINISH:
            begin
                state_next = t2c_pkg::ST_IDLE;
            end
            t2c_pkg::ST_READ_MEM:
            begin
                state_next = t2c_pkg::ST_READ_OUT;
            end
            t2c_pkg::ST_READ_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = t2c_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = t2c_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        load_count_next = load_count_reg;
        pend_ovf_next   = pend_ovf_reg;
        total_next      = total_reg;
        ovf_next        = ovf_reg;
        col_next        = col_reg;
        last_next       = last_reg;
        c_next          = c_reg;
        sum_next        = sum_reg;
        k_next          = k_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_load        = 1'b0;

        add_a = '0;
        add_b = '0;

        st_we     = 1'b0;
        st_wdata  = '{row: items.row, column: items.column, value: items.value};
        pl_we     = 1'b0;
        pl_waddr  = rd_count[ENTRY_AW-1:0];
        pl_wdata  = '{row: st_rd_reg.row,
                      value: carry_reg ? st_rd_reg.value : '0};
        o2n_we    = 1'b0;
        starts_we = 1'b0;

        cnt_ctl.rd_addr   = items.column[COL_AW-1:0];
        cnt_ctl.wr_en     = 1'b0;
        cnt_ctl.wr_addr   = col_reg;
        cnt_ctl.wr_data   = add_sum;
        cnt_ctl.clear_all = 1'b0;

        case (state_reg)
            t2c_pkg::ST_IDLE:
            begin
                c_next   = '0;
                sum_next = '0;
                k_next   = '0;
                if (in_fire)
                begin
                    col_next  = items.column[COL_AW-1:0];
                    last_next = items.last;
                    idx_next  = items.read_index;
                    if (items.kind == t2c_pkg::KIND_LOAD && col_ok)
                    begin
                        if (room)
                        begin
                            st_we = 1'b1;
                        end
                        else
                        begin
                            pend_ovf_next = 1'b1;
                        end
                    end
                end
            end
            t2c_pkg::ST_LOAD_RMW:
            begin
                add_a           = rd_count;
                add_b           = CNT_W'(1);
                cnt_ctl.wr_en   = 1'b1;
                cnt_ctl.wr_addr = col_reg;
                load_count_next = load_count_reg + CNT_W'(1);
            end
            t2c_pkg::ST_PFX_RD:
            begin
                cnt_ctl.rd_addr = c_reg;
            end
            t2c_pkg::ST_PFX_WR:
            begin
                // Exclusive prefix: the start goes out, and the count entry becomes
                // the next free slot of its column for the scatter pass.
                add_a           = sum_reg;
                add_b           = rd_count;
                sum_next        = add_sum;
                starts_we       = 1'b1;
                cnt_ctl.wr_en   = 1'b1;
                cnt_ctl.wr_addr = c_reg;
                cnt_ctl.wr_data = sum_reg;
                c_next          = c_reg + COL_AW'(1);
            end
            t2c_pkg::ST_SCT_CNT:
            begin
                cnt_ctl.rd_addr = st_rd_reg.column[COL_AW-1:0];
            end
            t2c_pkg::ST_SCT_WR:
            begin
                add_a           = rd_count;
                add_b           = CNT_W'(1);
                cnt_ctl.wr_en   = 1'b1;
                cnt_ctl.wr_addr = st_rd_reg.column[COL_AW-1:0];
                pl_we           = 1'b1;
                o2n_we          = 1'b1;
                k_next          = k_inc[ENTRY_AW-1:0];
            end
            t2c_pkg::ST_FINISH:
            begin
                cnt_ctl.clear_all = 1'b1;
                total_next        = load_count_reg;
                ovf_next          = pend_ovf_reg;
                load_count_next   = '0;
                pend_ovf_next     = 1'b0;
            end
            t2c_pkg::ST_READ_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_load       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= t2c_pkg::ST_IDLE;
            load_count_reg <= '0;
            pend_ovf_reg   <= 1'b0;
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            last_reg       <= 1'b0;
            c_reg          <= '0;
            sum_reg        <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            pend_ovf_reg   <= pend_ovf_next;
            total_reg      <= total_next;
            ovf_reg        <= ovf_next;
            last_reg       <= last_next;
            c_reg          <= c_next;
            sum_reg        <= sum_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        idx_reg <= idx_next;
        if (out_load)
        begin
            out_row_reg   <= idx_lt_total ? pl_rd_reg.row : '0;
            out_value_reg <= idx_lt_total ? pl_rd_reg.value : '0;
            out_pos_reg   <= idx_lt_total ? o2n_rd_reg : '0;
            out_start_reg <= idx_lt_cols ? starts_rd_reg : total_reg;
            out_total_reg <= total_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            staged_mem[load_count_reg[ENTRY_AW-1:0]] <= st_wdata;
        end
        st_rd_reg <= staged_mem[k_reg];

        if (pl_we)
        begin
            placed_mem[pl_waddr] <= pl_wdata;
        end
        pl_rd_reg <= placed_mem[idx_reg[ENTRY_AW-1:0]];

        if (o2n_we)
        begin
            o2n_mem[k_reg] <= rd_count[ENTRY_AW-1:0];
        end
        o2n_rd_reg <= o2n_mem[idx_reg[ENTRY_AW-1:0]];

        if (starts_we)
        begin
            starts_mem[c_reg] <= sum_reg;
        end
        starts_rd_reg <= starts_mem[idx_reg[COL_AW-1:0]];
    end

    assign results.valid         = out_valid_reg;
    assign results.entry_row     = out_row_reg;
    assign results.entry_value   = out_value_reg;
    assign results.column_start  = out_start_reg;
    assign results.new_position  = out_pos_reg;
    assign results.total_entries = out_total_reg;
    assign results.overflow      = out_ovf_reg;

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == t2c_pkg::ST_READ_OUT))
        else $error("result word appeared without a read");

    a_load_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= CNT_W'(t2c_pkg::MAX_ENTRIES))
        else $error("load count beyond capacity");

    a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && items.kind == t2c_pkg::KIND_LOAD && items.last) |=> !items.ready)
        else $error("input taken while a conversion should run");

    a_finish_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == t2c_pkg::ST_FINISH) |=>
            (total_reg == $past(load_count_reg) && load_count_reg == '0))
        else $error("conversion total not taken from load count");

endmodule

@@ rtl/t2c_counts.sv @@
module t2c_counts (
    input  logic                      clk,
    input  logic                      rst_n,
    input  t2c_pkg::cnt_ctl_t         ctl,
    output logic [t2c_pkg::CNT_W-1:0] rd_count
);

    logic [t2c_pkg::CNT_W-1:0]    count_mem [t2c_pkg::MAX_COLS];
    logic [t2c_pkg::MAX_COLS-1:0] valid_reg;
    logic [t2c_pkg::MAX_COLS-1:0] valid_next;
    logic [t2c_pkg::CNT_W-1:0]    rd_data_reg;
    logic                         rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            count_mem[ctl.wr_addr] <= ctl.wr_data;
        end
        rd_data_reg <= count_mem[ctl.rd_addr];
    end

    // An entry whose valid bit is clear reads as zero, so a whole clear only resets the valid bits.
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear_all)
        begin
            valid_next = '0;
        end
        else if (ctl.wr_en)
        begin
            valid_next[ctl.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[ctl.rd_addr];
        end
    end

    assign rd_count = rd_valid_reg ? rd_data_reg : '0;

endmodule
